// File: design/edq_pkg.sv
package edq_pkg;

    localparam int MAX_ROW_BYTES_DEF = 4096;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_LEVELS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RIGHT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DOWN_RIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DOWN       = 3'd6;

    // reset values of the registers
    localparam logic [12:0] ROW_PIXELS_RST        = 13'd640;
    localparam logic [15:0] FRAME_ROWS_RST        = 16'd480;
    localparam logic [2:0]  BYTES_PER_PIXEL_RST   = 3'd1;
    localparam logic [7:0]  QUANT_LEVELS_RST      = 8'd1;
    localparam logic [7:0]  WEIGHT_RIGHT_RST      = 8'd7;
    localparam logic [7:0]  WEIGHT_DOWN_RIGHT_RST = 8'd1;
    localparam logic [7:0]  WEIGHT_DOWN_RST       = 8'd5;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_WSUM_ZERO = 2'd1;
    localparam logic [1:0] ST_ROW_LONG  = 2'd2;

    localparam int COL_W  = 16;
    localparam int ROW_W  = 16;
    localparam int PS_MAX = 7;

    localparam logic [7:0] ERR_LIMIT = 8'd245;
    localparam logic [7:0] PIX_MAX   = 8'd255;

    // q = (v * recip) >> RECIP_SHIFT is the quotient or one below it for v < 512
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_W     = 18;

    typedef logic [255:0][7:0]         t_step_tab;
    typedef logic [255:0][RECIP_W-1:0] t_recip_tab;

    // step u = 255 / rank, rank 0 counted as 1
    function automatic t_step_tab build_step_tab();
        t_step_tab tab;
        int        rk;
        int        u;
        for (int r = 0; r < 256; r++) begin
            rk = (r == 0) ? 1 : r;
            u  = 0;
            for (int q = 1; q < 256; q++) begin
                if (q * rk <= 255) begin
                    u++;
                end
            end
            tab[r] = 8'(u);
        end
        return tab;
    endfunction

    // floor(2^RECIP_SHIFT / u) for each rank, by shift and subtract
    function automatic t_recip_tab build_recip_tab();
        t_recip_tab          tab;
        t_step_tab           st;
        logic [RECIP_W:0]    rem;
        logic [RECIP_W:0]    num;
        logic [RECIP_W-1:0]  quo;
        st  = build_step_tab();
        num = (RECIP_W+1)'(1) << RECIP_SHIFT;
        for (int r = 0; r < 256; r++) begin
            rem = '0;
            quo = '0;
            for (int b = RECIP_W - 1; b >= 0; b--) begin
                rem = {rem[RECIP_W-1:0], num[b]};
                if (rem >= (RECIP_W+1)'(st[r])) begin
                    rem    = rem - (RECIP_W+1)'(st[r]);
                    quo[b] = 1'b1;
                end
            end
            tab[r] = quo;
        end
        return tab;
    endfunction

    localparam t_step_tab  STEP_TAB  = build_step_tab();
    localparam t_recip_tab RECIP_TAB = build_recip_tab();

endpackage

// File: design/error_diffusion_quantizer.sv
// A request steps through ACC, MUL, REM, MOD, PROD, DIV (high nibble, then low) and FIN,
// set by the remainder multiply chain and the per-lane four-bit-per-cycle share dividers;
// a zero weight sum or an over-long row sends it from IDLE straight to FIN.
// One request is in flight at a time; the output register lets the next request in while a
// result waits. The accumulator memory needs no clearing pass: the first row of a frame reads 0.
// Reset (synchronous, active low) restores the register defaults and restarts the frame.
module error_diffusion_quantizer #(
    parameter int MAX_ROW_BYTES = edq_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [edq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [edq_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_pixel_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_pixel_out,
    output logic                           o_frame_last,
    output logic [1:0]                     o_status
);

    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int PSW = $clog2(edq_pkg::PS_MAX + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ACC  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_REM  = 4'd3;
    localparam logic [3:0] S_MOD  = 4'd4;
    localparam logic [3:0] S_PROD = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;

    localparam int LANE_R  = 0;
    localparam int LANE_DR = 1;
    localparam int LANE_D  = 2;

    // configuration registers
    logic [12:0] r_row_pixels;
    logic [15:0] r_frame_rows;
    logic [2:0]  r_bpp;
    logic [7:0]  r_quant_levels;
    logic [7:0]  r_w_right;
    logic [7:0]  r_w_down_right;
    logic [7:0]  r_w_down;

    logic [3:0]                 r_state;
    logic [edq_pkg::COL_W-1:0]  r_col;
    logic [edq_pkg::ROW_W-1:0]  r_row;
    logic [7:0]                 r_pix;
    logic [8:0]                 r_v;
    logic [8:0]                 r_q0;
    logic [8:0]                 r_rem;
    logic [7:0]                 r_err;
    logic [7:0]                 r_result;
    logic [15:0]                r_dvd [3];
    logic [7:0]                 r_quo [3];
    logic                       r_div_hi;
    logic [7:0]                 r_tap_r  [edq_pkg::PS_MAX];
    logic [7:0]                 r_tap_dr [edq_pkg::PS_MAX];
    logic [7:0]                 r_acc_mem [MAX_ROW_BYTES];
    logic [7:0]                 r_rd_data;
    logic                       r_out_valid;
    logic [7:0]                 r_pixel_out;
    logic                       r_frame_last;
    logic [1:0]                 r_status;

    // derived configuration
    logic [2:0]                 ps;
    logic [PSW-1:0]             tap_sel;
    logic [15:0]                rows;
    logic [12:0]                rowpx;
    logic [15:0]                row_bytes;
    logic [9:0]                 wsum;
    logic [1:0]                 cur_status;
    logic [7:0]                 step_u;
    logic [edq_pkg::RECIP_W-1:0] recip;
    logic [7:0]                 w_lane [3];

    logic                       in_accept;
    logic                       fin_fire;
    logic                       has_back;
    logic                       col_last;
    logic                       row_last;
    logic                       mem_we;
    logic [7:0]                 mem_wdata;

    logic [7:0]                 n_acc;
    logic [8:0]                 n_v;
    logic [26:0]                n_prod;
    logic [8:0]                 n_rem;
    logic [8:0]                 n_rem_fix;
    logic [7:0]                 n_err;
    logic [8:0]                 n_sum;
    logic [7:0]                 n_result;
    logic [19:0]                n_div [3];

    // four restoring quotient bits; the quotient is known to stay below 256
    function automatic logic [19:0] div_nibble(logic [15:0] rem, logic [9:0] d, logic hi);
        logic [15:0] r;
        logic [3:0]  q;
        logic [16:0] sh;
        int          b;
        r = rem;
        q = '0;
        for (int k = 0; k < 4; k++) begin
            b  = hi ? 7 - k : 3 - k;
            sh = 17'(d) << b;
            if (17'(r) >= sh) begin
                r        = 16'(17'(r) - sh);
                q[3 - k] = 1'b1;
            end
        end
        return {r, q};
    endfunction

    always_comb begin
        ps        = (r_bpp == 3'd0) ? 3'd1 : r_bpp;
        tap_sel   = PSW'(ps - 3'd1);
        rows      = (r_frame_rows == 16'd0) ? 16'd1 : r_frame_rows;
        rowpx     = (r_row_pixels == 13'd0) ? 13'd1 : r_row_pixels;
        row_bytes = 16'(rowpx) * 16'(ps);
        wsum      = 10'(r_w_right) + 10'(r_w_down_right) + 10'(r_w_down);
        if (wsum == 10'd0) begin
            cur_status = edq_pkg::ST_WSUM_ZERO;
        end else if (17'(row_bytes) > 17'(MAX_ROW_BYTES)) begin
            cur_status = edq_pkg::ST_ROW_LONG;
        end else begin
            cur_status = edq_pkg::ST_OK;
        end
        step_u = edq_pkg::STEP_TAB[r_quant_levels];
        recip  = edq_pkg::RECIP_TAB[r_quant_levels];
        w_lane[LANE_R]  = r_w_right;
        w_lane[LANE_DR] = r_w_down_right;
        w_lane[LANE_D]  = r_w_down;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign fin_fire   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign has_back   = (r_col >= edq_pkg::COL_W'(ps));
    assign col_last   = (17'(r_col) + 17'd1) >= 17'(row_bytes);
    assign row_last   = (17'(r_row) + 17'd1) >= 17'(rows);

    // datapath steps
    always_comb begin
        n_acc     = ((r_row == '0) ? 8'd0 : r_rd_data) + (has_back ? r_tap_r[tap_sel] : 8'd0);
        n_v       = 9'(r_pix) + 9'(n_acc);
        n_prod    = 27'(r_v) * 27'(recip);
        n_rem     = 9'(17'(r_v) - 17'(r_q0) * 17'(step_u));
        n_rem_fix = (r_rem >= 9'(step_u)) ? (r_rem - 9'(step_u)) : r_rem;
        n_err     = (n_rem_fix[7:0] >= edq_pkg::ERR_LIMIT) ? 8'd0 : n_rem_fix[7:0];
        n_sum     = r_v - 9'(n_err);
        n_result  = (n_sum > 9'(edq_pkg::PIX_MAX)) ? edq_pkg::PIX_MAX : n_sum[7:0];
        for (int l = 0; l < 3; l++) begin
            n_div[l] = div_nibble(r_dvd[l], wsum, r_div_hi);
        end
    end

    // the entry of this column takes the down share plus the lower right share from ps back
    assign mem_we    = fin_fire && (cur_status == edq_pkg::ST_OK);
    assign mem_wdata = r_quo[LANE_D] + (has_back ? r_tap_dr[tap_sel] : 8'd0);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_acc_mem[r_col[AW-1:0]] <= mem_wdata;
        end
    end

    // read the previous row's entry for this column
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= r_acc_mem[r_col[AW-1:0]];
        end
    end

    // configuration and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pixels   <= edq_pkg::ROW_PIXELS_RST;
            r_frame_rows   <= edq_pkg::FRAME_ROWS_RST;
            r_bpp          <= edq_pkg::BYTES_PER_PIXEL_RST;
            r_quant_levels <= edq_pkg::QUANT_LEVELS_RST;
            r_w_right      <= edq_pkg::WEIGHT_RIGHT_RST;
            r_w_down_right <= edq_pkg::WEIGHT_DOWN_RIGHT_RST;
            r_w_down       <= edq_pkg::WEIGHT_DOWN_RST;
            r_state        <= S_IDLE;
            r_col          <= '0;
            r_row          <= '0;
            r_div_hi       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    edq_pkg::REG_ROW_PIXELS: begin
                        r_row_pixels <= i_cfg_wdata[12:0];
                        r_col <= '0;
                        r_row <= '0;
                    end
                    edq_pkg::REG_FRAME_ROWS: begin
                        r_frame_rows <= i_cfg_wdata;
                        r_col <= '0;
                        r_row <= '0;
                    end
                    edq_pkg::REG_BYTES_PER_PIXEL: begin
                        r_bpp <= i_cfg_wdata[2:0];
                        r_col <= '0;
                        r_row <= '0;
                    end
                    edq_pkg::REG_QUANT_LEVELS: begin
                        r_quant_levels <= i_cfg_wdata[7:0];
                        r_col <= '0;
                        r_row <= '0;
                    end
                    edq_pkg::REG_WEIGHT_RIGHT: begin
                        r_w_right <= i_cfg_wdata[7:0];
                        r_col <= '0;
                        r_row <= '0;
                    end
                    edq_pkg::REG_WEIGHT_DOWN_RIGHT: begin
                        r_w_down_right <= i_cfg_wdata[7:0];
                        r_col <= '0;
                        r_row <= '0;
                    end
                    edq_pkg::REG_WEIGHT_DOWN: begin
                        r_w_down <= i_cfg_wdata[7:0];
                        r_col <= '0;
                        r_row <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (fin_fire) begin
                // advance the raster position
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end

            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= (cur_status == edq_pkg::ST_OK) ? S_ACC : S_FIN;
                    end
                end
                S_ACC:  r_state <= S_MUL;
                S_MUL:  r_state <= S_REM;
                S_REM:  r_state <= S_MOD;
                S_MOD:  r_state <= S_PROD;
                S_PROD: begin
                    r_state  <= S_DIV;
                    r_div_hi <= 1'b1;
                end
                S_DIV: begin
                    r_div_hi <= 1'b0;
                    if (!r_div_hi) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pix    <= i_pixel_in;
            r_result <= 8'd0;
            for (int l = 0; l < 3; l++) begin
                r_quo[l] <= 8'd0;
            end
        end
        if (r_state == S_ACC) begin
            r_v <= n_v;
        end
        if (r_state == S_MUL) begin
            r_q0 <= n_prod[edq_pkg::RECIP_SHIFT+8:edq_pkg::RECIP_SHIFT];
        end
        if (r_state == S_REM) begin
            r_rem <= n_rem;
        end
        if (r_state == S_MOD) begin
            r_err    <= n_err;
            r_result <= n_result;
        end
        if (r_state == S_PROD) begin
            for (int l = 0; l < 3; l++) begin
                r_dvd[l] <= 16'(r_err) * 16'(w_lane[l]);
            end
        end
        if (r_state == S_DIV) begin
            for (int l = 0; l < 3; l++) begin
                r_dvd[l] <= n_div[l][19:4];
                if (r_div_hi) begin
                    r_quo[l][7:4] <= n_div[l][3:0];
                end else begin
                    r_quo[l][3:0] <= n_div[l][3:0];
                end
            end
        end
        if (fin_fire) begin
            // push this column's right and lower right shares into the delay lines
            r_tap_r[0]  <= r_quo[LANE_R];
            r_tap_dr[0] <= r_quo[LANE_DR];
            for (int t = 1; t < edq_pkg::PS_MAX; t++) begin
                r_tap_r[t]  <= r_tap_r[t-1];
                r_tap_dr[t] <= r_tap_dr[t-1];
            end
            r_pixel_out  <= r_result;
            r_frame_last <= col_last && row_last;
            r_status     <= cur_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_pixel_out;
    assign o_frame_last = r_frame_last;
    assign o_status     = r_status;

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < row_bytes)
        else $error("column position beyond row length");

    a_mem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (17'(row_bytes) <= 17'(MAX_ROW_BYTES)))
        else $error("accumulator write with row longer than store");

    a_err_below_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROD) |-> (r_err < step_u))
        else $error("remainder not below step");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("second request taken while one is in flight");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !r_div_hi) |=> (r_state == S_FIN))
        else $error("share division did not finish in two cycles");
`endif

endmodule

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 4;
    localparam int MAX_BYTES    = edq_pkg::MAX_ROW_BYTES_DEF;
    localparam int ITEM_TARGET  = 950;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 24;
    localparam int PLAN_LEN     = 37;
    localparam int LONG_ROW_PX  = 64;
    localparam int LONG_BPP     = 4;

    // index past the end of the register list, which the block must ignore
    localparam logic [edq_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef enum logic [1:0] {
        STEP_WRITE,
        STEP_PIX,
        STEP_PIX_KNOWN
    } t_step_kind;

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
        logic [1:0] status;
    } t_pixel_result;

    typedef struct packed {
        t_step_kind                        kind;
        logic [edq_pkg::CFG_IDX_W-1:0]     idx;
        logic [edq_pkg::CFG_DATA_W-1:0]    data;
        logic [7:0]                        pix;
        logic [7:0]                        want_pix;
        logic                              want_last;
        logic [1:0]                        want_status;
    } t_plan_step;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [edq_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [edq_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    logic [7:0]                     i_pixel_in  = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [7:0]                     o_pixel_out;
    logic                           o_frame_last;
    logic [1:0]                     o_status;

    // register copies and error stores of the predictor
    logic [12:0] reg_row_px;
    logic [15:0] reg_rows;
    logic [2:0]  reg_bpp;
    logic [7:0]  reg_levels;
    logic [7:0]  reg_w_r;
    logic [7:0]  reg_w_dr;
    logic [7:0]  reg_w_d;
    logic [7:0]  err_now   [MAX_BYTES];
    logic [7:0]  err_below [MAX_BYTES];
    int unsigned byte_col;
    int unsigned line_idx;

    t_pixel_result due_pixels [$];

    int error_count  = 0;
    int items_sent   = 0;
    int frames_seen  = 0;
    int setups       = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_asks    = 0;
    int holds_done   = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int phase_no     = 0;

    t_plan_step plan [PLAN_LEN] = '{
        '{STEP_PIX_KNOWN, REG_NONE, 16'h0000, 8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX_KNOWN, REG_NONE, 16'h0000, 8'hFF, 8'hFF, 1'b0, edq_pkg::ST_OK},
        // error of 245 or more is dropped
        '{STEP_PIX_KNOWN, REG_NONE, 16'h0000, 8'hFA, 8'hFA, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX,       REG_NONE, 16'h0000, 8'hC8, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX,       REG_NONE, 16'h0000, 8'hFF, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_QUANT_LEVELS, 16'h00FF,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX_KNOWN, REG_NONE, 16'h0000, 8'h81, 8'h81, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX_KNOWN, REG_NONE, 16'h0000, 8'h7E, 8'h7E, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_WEIGHT_RIGHT, 16'h0000,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_WEIGHT_DOWN_RIGHT, 16'h0000,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_WEIGHT_DOWN, 16'h0000,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX_KNOWN, REG_NONE, 16'h0000, 8'hFF, 8'h00, 1'b0, edq_pkg::ST_WSUM_ZERO},
        '{STEP_WRITE, edq_pkg::REG_ROW_PIXELS, 16'hFFFF,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        // zero weight sum wins over the over-long row
        '{STEP_PIX_KNOWN, REG_NONE, 16'h0000, 8'h00, 8'h00, 1'b0, edq_pkg::ST_WSUM_ZERO},
        '{STEP_WRITE, edq_pkg::REG_WEIGHT_DOWN, 16'h00FF,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX_KNOWN, REG_NONE, 16'h0000, 8'h55, 8'h00, 1'b0, edq_pkg::ST_ROW_LONG},
        '{STEP_WRITE, edq_pkg::REG_ROW_PIXELS, 16'd4097,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX_KNOWN, REG_NONE, 16'h0000, 8'hAA, 8'h00, 1'b0, edq_pkg::ST_ROW_LONG},
        // zero sizes count as one: every byte ends the frame
        '{STEP_WRITE, edq_pkg::REG_ROW_PIXELS, 16'h0000,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_FRAME_ROWS, 16'h0000,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_BYTES_PER_PIXEL, 16'h0000,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX_KNOWN, REG_NONE, 16'h0000, 8'h3C, 8'h3C, 1'b1, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_WEIGHT_RIGHT, 16'h00FF,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_WEIGHT_DOWN_RIGHT, 16'h00FF,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_QUANT_LEVELS, 16'h0000,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_ROW_PIXELS, 16'd2,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_FRAME_ROWS, 16'd2,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_BYTES_PER_PIXEL, 16'hFFF9,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX,       REG_NONE, 16'h0000, 8'hC8, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX,       REG_NONE, 16'h0000, 8'hFF, 8'h00, 1'b0, edq_pkg::ST_OK},
        // ignored write mid-frame: the frame must carry on
        '{STEP_WRITE,     REG_NONE, 16'h1234, 8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX,       REG_NONE, 16'h0000, 8'hFF, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX,       REG_NONE, 16'h0000, 8'hFF, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_BYTES_PER_PIXEL, 16'h0007,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_WRITE, edq_pkg::REG_FRAME_ROWS, 16'hFFFF,
          8'h00, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX,       REG_NONE, 16'h0000, 8'hF5, 8'h00, 1'b0, edq_pkg::ST_OK},
        '{STEP_PIX,       REG_NONE, 16'h0000, 8'h0A, 8'h00, 1'b0, edq_pkg::ST_OK}
    };

    error_diffusion_quantizer #(
        .MAX_ROW_BYTES(MAX_BYTES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_out (o_pixel_out),
        .o_frame_last(o_frame_last),
        .o_status    (o_status)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void restart_store();
        for (int k = 0; k < MAX_BYTES; k++) begin
            err_now[k]   = 8'd0;
            err_below[k] = 8'd0;
        end
        byte_col = 0;
        line_idx = 0;
    endfunction

    function automatic void load_defaults();
        reg_row_px = edq_pkg::ROW_PIXELS_RST;
        reg_rows   = edq_pkg::FRAME_ROWS_RST;
        reg_bpp    = edq_pkg::BYTES_PER_PIXEL_RST;
        reg_levels = edq_pkg::QUANT_LEVELS_RST;
        reg_w_r    = edq_pkg::WEIGHT_RIGHT_RST;
        reg_w_dr   = edq_pkg::WEIGHT_DOWN_RIGHT_RST;
        reg_w_d    = edq_pkg::WEIGHT_DOWN_RST;
        restart_store();
    endfunction

    function automatic void load_register(input logic [edq_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [edq_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            edq_pkg::REG_ROW_PIXELS:        reg_row_px = data[12:0];
            edq_pkg::REG_FRAME_ROWS:        reg_rows   = data[15:0];
            edq_pkg::REG_BYTES_PER_PIXEL:   reg_bpp    = data[2:0];
            edq_pkg::REG_QUANT_LEVELS:      reg_levels = data[7:0];
            edq_pkg::REG_WEIGHT_RIGHT:      reg_w_r    = data[7:0];
            edq_pkg::REG_WEIGHT_DOWN_RIGHT: reg_w_dr   = data[7:0];
            edq_pkg::REG_WEIGHT_DOWN:       reg_w_d    = data[7:0];
            default:                        return;
        endcase
        restart_store();
    endfunction

    // quantize one byte, spread its error and advance the raster position
    function automatic t_pixel_result diffuse_pixel(input logic [7:0] pix);
        t_pixel_result res;
        int unsigned   ps;
        int unsigned   rows;
        int unsigned   rp;
        int unsigned   rbytes;
        int unsigned   wsum;
        int unsigned   j;
        int unsigned   rank;
        int unsigned   step;
        int unsigned   v;
        int unsigned   e;
        int unsigned   q;
        int unsigned   span;
        res.pix    = 8'd0;
        res.status = edq_pkg::ST_OK;
        ps     = (reg_bpp == 0) ? 1 : reg_bpp;
        rows   = (reg_rows == 0) ? 1 : reg_rows;
        rp     = (reg_row_px == 0) ? 1 : reg_row_px;
        rbytes = rp * ps;
        wsum   = reg_w_r + reg_w_dr + reg_w_d;
        j      = byte_col;
        if (wsum == 0) begin
            res.status = edq_pkg::ST_WSUM_ZERO;
        end else if (rbytes > MAX_BYTES) begin
            res.status = edq_pkg::ST_ROW_LONG;
        end else begin
            rank = (reg_levels == 0) ? 1 : reg_levels;
            step = edq_pkg::PIX_MAX / rank;
            v    = pix + err_now[j];
            e    = v % step;
            if (e >= edq_pkg::ERR_LIMIT) begin
                e = 0;
            end
            q = v - e;
            if (q > edq_pkg::PIX_MAX) begin
                q = edq_pkg::PIX_MAX;
            end
            res.pix    = 8'(q);
            err_now[j] = 8'(q);
            if (j + ps < rbytes) begin
                err_now[j + ps] = err_now[j + ps] + 8'(e * reg_w_r / wsum);
                if (line_idx + 1 < rows) begin
                    err_below[j + ps] = err_below[j + ps] + 8'(e * reg_w_dr / wsum);
                end
            end
            if (line_idx + 1 < rows) begin
                err_below[j] = err_below[j] + 8'(e * reg_w_d / wsum);
            end
        end
        res.last = (line_idx + 1 >= rows) && (j + 1 >= rbytes);
        if (j + 1 >= rbytes) begin
            byte_col = 0;
            if (line_idx + 1 >= rows) begin
                restart_store();
            end else begin
                line_idx++;
                // entries past the row are never touched, so move only the row
                span = (rbytes > MAX_BYTES) ? MAX_BYTES : rbytes;
                for (int k = 0; k < span; k++) begin
                    err_now[k]   = err_below[k];
                    err_below[k] = 8'd0;
                end
            end
        end else begin
            byte_col = j + 1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_gap_pct = 53; stall_pct = 0;  end
            2:       begin send_gap_pct = 0;  stall_pct = 53; end
            3:       begin send_gap_pct = 36; stall_pct = 36; end
            default: begin send_gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // drop valid and hold until every predicted byte has come back
    task automatic wait_settled();
        i_in_valid <= 1'b0;
        while (due_pixels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [edq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [edq_pkg::CFG_DATA_W-1:0] data);
        wait_settled();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        load_register(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_pixel(input logic [7:0] pix, input bit typed,
                              input t_pixel_result typed_res);
        t_pixel_result pred;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        pred = diffuse_pixel(pix);
        due_pixels.push_back(typed ? typed_res : pred);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(245, 254));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int mode, input bit squeeze);
        int unsigned rp;
        int unsigned rows;
        int unsigned bpp;
        int unsigned lv;
        int unsigned wr;
        int unsigned wdr;
        int unsigned wd;
        int unsigned flavour;
        int unsigned frame_bytes;
        int unsigned n;
        flavour = $urandom_range(0, 19);
        rp      = $urandom_range(0, 8);
        rows    = $urandom_range(0, 6);
        bpp     = $urandom_range(0, 7);
        wr      = $urandom_range(0, 255);
        wdr     = $urandom_range(0, 255);
        wd      = $urandom_range(0, 255);
        if ($urandom_range(0, 3) == 0) begin
            wr  = $urandom_range(0, 15);
            wdr = $urandom_range(0, 15);
            wd  = $urandom_range(0, 15);
        end
        case ($urandom_range(0, 7))
            0:       lv = 0;
            1:       lv = 1;
            2:       lv = 2;
            3:       lv = 255;
            default: lv = $urandom_range(0, 255);
        endcase
        if (flavour == 0) begin
            wr  = 0;
            wdr = 0;
            wd  = 0;
        end else if (flavour == 1) begin
            if ($urandom_range(0, 1) == 0) begin
                rp  = $urandom_range(4097, 8191);
                bpp = 1;
            end else begin
                rp  = $urandom_range(586, 8191);
                bpp = 7;
            end
        end
        // upper data bits are random: the block must mask them off
        write_reg(edq_pkg::REG_ROW_PIXELS, {3'($urandom), 13'(rp)});
        write_reg(edq_pkg::REG_FRAME_ROWS, 16'(rows));
        write_reg(edq_pkg::REG_BYTES_PER_PIXEL, {13'($urandom), 3'(bpp)});
        write_reg(edq_pkg::REG_QUANT_LEVELS, {8'($urandom), 8'(lv)});
        write_reg(edq_pkg::REG_WEIGHT_RIGHT, {8'($urandom), 8'(wr)});
        write_reg(edq_pkg::REG_WEIGHT_DOWN_RIGHT, {8'($urandom), 8'(wdr)});
        write_reg(edq_pkg::REG_WEIGHT_DOWN, {8'($urandom), 8'(wd)});
        setups++;
        set_idling(mode);
        frame_bytes = ((rp == 0) ? 1 : rp) * ((bpp == 0) ? 1 : bpp) * ((rows == 0) ? 1 : rows);
        if (flavour <= 1) begin
            n = $urandom_range(4, 24);
        end else begin
            n = frame_bytes * $urandom_range(1, 2) + $urandom_range(0, frame_bytes - 1);
            if (n > 300) begin
                n = 300;
            end
        end
        if (squeeze) begin
            if (n < 80) begin
                n = 80;
            end
            // ask the receiver for a long hold-off so the block backs up
            hold_asks++;
        end
        for (int k = 0; k < n; k++) begin
            push_pixel(pick_pixel(), 1'b0, '0);
        end
    endtask

    // receiver: random stalls plus the long hold-off on request
    always @(posedge i_clk) begin
        if (holds_done != hold_asks) begin
            holds_done = hold_asks;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pixel_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_pixels.size() == 0) begin
                report_mismatch("result with nothing due, pixel", o_pixel_out, -1);
            end else begin
                want = due_pixels.pop_front();
                if (o_pixel_out !== want.pix) begin
                    report_mismatch("pixel_out", o_pixel_out, want.pix);
                end
                if (o_frame_last !== want.last) begin
                    report_mismatch("frame_last", o_frame_last, want.last);
                end
                if (o_status !== want.status) begin
                    report_mismatch("status", o_status, want.status);
                end
            end
            if (o_frame_last) begin
                frames_seen++;
            end
            status_seen[o_status]++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        load_defaults();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < PLAN_LEN; k++) begin
            case (plan[k].kind)
                STEP_WRITE: write_reg(plan[k].idx, plan[k].data);
                STEP_PIX:   push_pixel(plan[k].pix, 1'b0, '0);
                default:    push_pixel(plan[k].pix, 1'b1,
                                       {plan[k].want_pix, plan[k].want_last,
                                        plan[k].want_status});
            endcase
        end

        while (items_sent < ITEM_TARGET) begin
            random_phase(phase_no % 4, phase_no == 2);
            phase_no++;
        end

        // a longer row of four-byte pixels, two rows deep
        write_reg(edq_pkg::REG_ROW_PIXELS, 16'(LONG_ROW_PX));
        write_reg(edq_pkg::REG_FRAME_ROWS, 16'd2);
        write_reg(edq_pkg::REG_BYTES_PER_PIXEL, 16'(LONG_BPP));
        write_reg(edq_pkg::REG_QUANT_LEVELS, 16'($urandom_range(0, 8)));
        write_reg(edq_pkg::REG_WEIGHT_RIGHT, 16'($urandom_range(1, 255)));
        write_reg(edq_pkg::REG_WEIGHT_DOWN_RIGHT, 16'($urandom_range(1, 255)));
        write_reg(edq_pkg::REG_WEIGHT_DOWN, 16'($urandom_range(1, 255)));
        setups++;
        set_idling(0);
        for (int k = 0; k < 2 * LONG_ROW_PX * LONG_BPP; k++) begin
            push_pixel(pick_pixel(), 1'b0, '0);
        end

        wait_settled();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes over %0d random setups, %0d frame ends",
                 items_sent, setups, frames_seen);
        $display("statuses: %0d ok, %0d zero weight sum, %0d row over store, %0d errors",
                 status_seen[edq_pkg::ST_OK], status_seen[edq_pkg::ST_WSUM_ZERO],
                 status_seen[edq_pkg::ST_ROW_LONG], error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
